// File: rtl/srrw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_pkg
// Shared types and constants of the selective repeat receive window.
// ----------------------------------------------------------------------------
package srrw_pkg;

  localparam int WINDOW_MAX_DFLT = 16;
  localparam int MAX_PAYLOAD     = 1024;

  localparam int SEQ_W    = 31;
  localparam int HANDLE_W = 16;
  localparam int LEN_W    = 11;
  localparam int WSIZE_W  = 5;
  localparam int START_W  = 30;
  localparam int WCOUNT_W = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 30;

  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  localparam logic [WSIZE_W-1:0] WSIZE_RESET = WSIZE_W'(4);
  localparam logic [START_W-1:0] START_RESET = START_W'(0);

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_START_SEQ   = CFG_IDX_W'(1);

  localparam logic RESULT_ACK     = 1'b0;
  localparam logic RESULT_DELIVER = 1'b1;

  typedef struct packed {
    logic [SEQ_W-1:0]    packet_seq;
    logic [HANDLE_W-1:0] packet_handle;
    logic [LEN_W-1:0]    packet_length;
  } in_item_t;

  typedef struct packed {
    logic                result_kind;
    logic [SEQ_W-1:0]    result_seq;
    logic [HANDLE_W-1:0] delivered_handle;
    logic [LEN_W-1:0]    delivered_length;
    logic                last_result;
  } out_item_t;

  typedef struct packed {
    logic [SEQ_W-1:0]    seq;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    length;
    logic                in_space;
  } cmd_t;

  typedef struct packed {
    logic [SEQ_W-1:0]    seq;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    length;
  } slot_t;

  typedef struct packed {
    logic                rearm;
    logic [WCOUNT_W-1:0] win;
    logic [START_W-1:0]  start;
    logic [SEQ_W-1:0]    top;
  } cfg_view_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_IDX,
    BK_ACK,
    BK_DRAIN_RD,
    BK_DRAIN
  } back_state_t;

endpackage

// File: rtl/srrw_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_fifo
// Small first-in first-out queue in flops, head entry shown combinationally.
// ----------------------------------------------------------------------------
module srrw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: rtl/srrw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module srrw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

// File: rtl/srrw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_front
// Configuration registers, packet intake and sequence space classification,
// with a short command queue toward the window engine.
// ----------------------------------------------------------------------------
module srrw_front import srrw_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DFLT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_data,
  output cfg_view_t             cfg_view,
  output logic                  cmd_valid,
  output cmd_t                  cmd,
  input  logic                  cmd_pop
);

  logic [WSIZE_W-1:0]  wsize_r;
  logic [START_W-1:0]  start_r;
  logic                rearm_r;
  logic [WCOUNT_W-1:0] win;
  logic [SEQ_W-1:0]    top;
  cmd_t                cmd_in;
  logic                cmd_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsize_r <= WSIZE_RESET;
      start_r <= START_RESET;
      rearm_r <= 1'b0;
    end else begin
      rearm_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WINDOW_SIZE: wsize_r <= cfg_data[WSIZE_W-1:0];
          CFG_START_SEQ:   start_r <= cfg_data[START_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    if (wsize_r == '0) begin
      win = WCOUNT_W'(1);
    end else if (int'(wsize_r) > WINDOW_MAX) begin
      win = WCOUNT_W'(WINDOW_MAX);
    end else begin
      win = WCOUNT_W'(wsize_r);
    end
  end

  assign top = SEQ_W'(start_r) + SEQ_W'({win, 1'b0});

  assign cfg_view.rearm = rearm_r;
  assign cfg_view.win   = win;
  assign cfg_view.start = start_r;
  assign cfg_view.top   = top;

  always_comb begin
    cmd_in.seq      = in_data.packet_seq;
    cmd_in.handle   = in_data.packet_handle;
    cmd_in.length   = (in_data.packet_length > LEN_W'(MAX_PAYLOAD)) ?
                      LEN_W'(MAX_PAYLOAD) : in_data.packet_length;
    cmd_in.in_space = (in_data.packet_seq >= SEQ_W'(start_r)) &&
                      (in_data.packet_seq <= top);
  end

  srrw_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd),
    .empty (cmd_empty)
  );

  assign cmd_valid = !cmd_empty;

endmodule

// File: rtl/srrw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_back
// Window engine: window offset, slot store with duplicate check, in-order
// drain of filled slots at the head.
// ----------------------------------------------------------------------------
module srrw_back import srrw_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DFLT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_view_t cfg_view,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output logic      res_push,
  output out_item_t res_data,
  input  logic      res_full
);

  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  back_state_t           state_r, state_nxt;
  cmd_t                  cmd_r;
  logic [IDX_W-1:0]      pos_r;
  logic                  in_win_r;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [SEQ_W-1:0]      base_r, base_nxt;
  logic [WINDOW_MAX-1:0] full_r, full_nxt;

  logic [31:0]      seq_x, base_x, span_x, pos_x;
  logic             in_win_nxt;
  logic [IDX_W:0]   win_i, idx_sum, head_inc;
  logic [IDX_W-1:0] nh;
  logic [SEQ_W-1:0] base_adv;
  logic             dup, store, ack_more, drain_more;

  logic             ram_we;
  logic [IDX_W-1:0] ram_raddr;
  slot_t            ram_wdata, ram_rdata;

  assign seq_x  = {1'b0, cmd.seq};
  assign base_x = {1'b0, base_r};
  assign span_x = 32'({cfg_view.win, 1'b0}) + 32'd1;
  assign pos_x  = (cmd.seq >= base_r) ? (seq_x - base_x) : (seq_x + span_x - base_x);
  assign in_win_nxt = cmd.in_space && (pos_x < 32'(cfg_view.win));

  assign win_i    = (IDX_W + 1)'(cfg_view.win);
  assign idx_sum  = {1'b0, head_r} + {1'b0, pos_r};
  assign idx_nxt  = (idx_sum >= win_i) ? IDX_W'(idx_sum - win_i) : idx_sum[IDX_W-1:0];
  assign head_inc = {1'b0, head_r} + (IDX_W + 1)'(1);
  assign nh       = (head_inc >= win_i) ? '0 : head_inc[IDX_W-1:0];
  assign base_adv = (base_r < cfg_view.top) ? base_r + SEQ_W'(1) : SEQ_W'(cfg_view.start);

  assign dup        = full_r[idx_r] && (ram_rdata.seq == cmd_r.seq);
  assign store      = in_win_r && !dup;
  assign ack_more   = full_r[head_r] || (in_win_r && (idx_r == head_r));
  assign drain_more = full_r[nh] && (nh != head_r);

  assign ram_wdata.seq    = cmd_r.seq;
  assign ram_wdata.handle = cmd_r.handle;
  assign ram_wdata.length = cmd_r.length;

  always_comb begin
    state_nxt = state_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res_data  = '0;
    ram_we    = 1'b0;
    ram_raddr = head_r;
    head_nxt  = head_r;
    base_nxt  = base_r;
    full_nxt  = full_r;
    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          state_nxt = BK_IDX;
        end
      end
      BK_IDX: begin
        ram_raddr = idx_nxt;
        state_nxt = BK_ACK;
      end
      BK_ACK: begin
        ram_raddr                 = idx_r;
        res_data.result_kind      = RESULT_ACK;
        res_data.result_seq       = cmd_r.seq;
        res_data.last_result      = !ack_more;
        if (!res_full) begin
          res_push = 1'b1;
          if (store) begin
            ram_we          = 1'b1;
            full_nxt[idx_r] = 1'b1;
          end
          state_nxt = ack_more ? BK_DRAIN_RD : BK_IDLE;
        end
      end
      BK_DRAIN_RD: begin
        ram_raddr = head_r;
        state_nxt = BK_DRAIN;
      end
      BK_DRAIN: begin
        res_data.result_kind      = RESULT_DELIVER;
        res_data.result_seq       = ram_rdata.seq;
        res_data.delivered_handle = ram_rdata.handle;
        res_data.delivered_length = ram_rdata.length;
        res_data.last_result      = !drain_more;
        if (!res_full) begin
          res_push         = 1'b1;
          ram_raddr        = nh;
          full_nxt[head_r] = 1'b0;
          head_nxt         = nh;
          base_nxt         = base_adv;
          state_nxt        = drain_more ? BK_DRAIN : BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      head_r  <= '0;
      base_r  <= SEQ_W'(START_RESET);
      full_r  <= '0;
    end else if (cfg_view.rearm) begin
      state_r <= BK_IDLE;
      head_r  <= '0;
      base_r  <= SEQ_W'(cfg_view.start);
      full_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      base_r  <= base_nxt;
      full_r  <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r    <= cmd;
      pos_r    <= pos_x[IDX_W-1:0];
      in_win_r <= in_win_nxt;
    end
    if (state_r == BK_IDX) begin
      idx_r <= idx_nxt;
    end
  end

  srrw_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (WINDOW_MAX)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// File: rtl/selective_repeat_receive_window_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_receive_window_core
// Selective repeat receiver window: acknowledge, store, deliver in order.
// ----------------------------------------------------------------------------
// Each accepted packet yields an acknowledgement, then every in-order packet
// that becomes deliverable, the final result flagged by last_result. A packet
// that delivers nothing uses the index and ack states; one that delivers also
// uses a drain read state, then the drain state once per delivery, set by the
// registered slot store read (before the duplicate check and the first
// delivery) and one result per cycle into the output queue unless full. Two
// packets and two results are buffered, so both sides stall independently.
// Slots are cleared on reset and each configuration write; no clearing pass.
// ----------------------------------------------------------------------------
module selective_repeat_receive_window_core import srrw_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DFLT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_data,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             out_data
);

  cfg_view_t cfg_view;
  logic      cmd_valid;
  cmd_t      cmd;
  logic      cmd_pop;
  logic      res_push;
  out_item_t res_data;
  logic      res_full;

  srrw_front #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cfg_view  (cfg_view),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  srrw_back #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_view  (cfg_view),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res_data  (res_data),
    .res_full  (res_full)
  );

  srrw_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_data),
    .empty (empty)
  );

`ifndef NO_ASSERTIONS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full output queue");

  a_rearm_follows_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> cfg_view.rearm)
    else $error("window not rearmed after a configuration write");

  a_ack_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && (res_data.result_kind == RESULT_ACK)) |->
      ((res_data.delivered_handle == '0) && (res_data.delivered_length == '0)))
    else $error("acknowledgement carries delivery payload");
`endif

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the selective repeat receive window core.
// ----------------------------------------------------------------------------
// A short scripted sequence covers reset defaults, window size and start
// sequence extremes, duplicates, saturated lengths and packets outside the
// window and outside the sequence space. Random phases follow, one for each
// register setting. Each phase sends mostly in-window packets and some out of
// range packets. Every accepted packet is run through a window model in the
// bench. Its predicted ack and deliveries, or typed script results, are queued
// and compared field by field with what the block pops. Both sides stall at
// random. One phase holds the receiver off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_top;
  import srrw_pkg::*;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 7;
  localparam int SETTLE_CYCLES   = 24;
  localparam int LONG_HOLD       = 300;
  localparam int HOLD_BURST      = 30;
  localparam int STALL_LIMIT     = 3000;
  localparam int PHASES          = 7;
  localparam int ITEMS_PER_PHASE = 72;
  localparam int SCRIPT_ROWS     = 26;
  localparam int MAX_REPORTS     = 40;

  typedef struct packed {
    bit                    is_reg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    in_item_t              pkt;
    int                    n_typed;
    out_item_t             first_res;
    out_item_t             second_res;
  } script_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  push;
  logic                  full;
  in_item_t              in_data;
  logic                  empty;
  logic                  pop;
  out_item_t             out_data;

  // window model
  logic [WSIZE_W-1:0]    size_reg;
  logic [START_W-1:0]    start_reg;
  bit                    occupied [WINDOW_MAX_DFLT];
  logic [SEQ_W-1:0]      held_seq [WINDOW_MAX_DFLT];
  logic [HANDLE_W-1:0]   held_handle [WINDOW_MAX_DFLT];
  logic [LEN_W-1:0]      held_length [WINDOW_MAX_DFLT];
  int unsigned           head_idx;
  int unsigned           base_seq;

  out_item_t             arrival_results [$];
  out_item_t             awaiting_results [$];

  int                    typed_n;
  out_item_t             typed_a;
  out_item_t             typed_b;
  bit                    hold_request = 1'b0;
  script_row_t           script [SCRIPT_ROWS];

  int mismatch_count  = 0;
  int packets_taken   = 0;
  int results_seen    = 0;
  int deliveries_seen = 0;
  int reg_writes      = 0;
  int holds_done      = 0;

  selective_repeat_receive_window_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  function automatic int unsigned window_slots();
    int unsigned w;
    w = 32'(size_reg);
    if (w < 1) w = 1;
    if (w > WINDOW_MAX_DFLT) w = WINDOW_MAX_DFLT;
    return w;
  endfunction

  function automatic void restart_window();
    foreach (occupied[i]) occupied[i] = 1'b0;
    head_idx = 0;
    base_seq = 32'(start_reg);
  endfunction

  function automatic void load_register(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_WINDOW_SIZE: size_reg = val[WSIZE_W-1:0];
      CFG_START_SEQ:   start_reg = val[START_W-1:0];
      default: ;
    endcase
    restart_window();
  endfunction

  // ack first, then every in-order delivery the arrival unblocks
  function automatic void window_receive(in_item_t p);
    int unsigned w, top, span, seq, len, pos, slot, steps;
    out_item_t r;
    w = window_slots();
    top = 32'(start_reg) + 2 * w;
    span = 2 * w + 1;
    seq = 32'(p.packet_seq);
    len = 32'(p.packet_length);
    if (len > MAX_PAYLOAD) len = MAX_PAYLOAD;
    arrival_results.delete();
    r = '0;
    r.result_kind = RESULT_ACK;
    r.result_seq = seq[SEQ_W-1:0];
    arrival_results.push_back(r);
    if (seq >= 32'(start_reg) && seq <= top) begin
      pos = (seq >= base_seq) ? seq - base_seq : seq + span - base_seq;
      if (pos < w) begin
        slot = (head_idx + pos) % w;
        if (!(occupied[slot] && held_seq[slot] == seq[SEQ_W-1:0])) begin
          occupied[slot] = 1'b1;
          held_seq[slot] = seq[SEQ_W-1:0];
          held_handle[slot] = p.packet_handle;
          held_length[slot] = len[LEN_W-1:0];
        end
      end
    end
    for (steps = 0; steps < w; steps++) begin
      if (!occupied[head_idx]) break;
      r = '0;
      r.result_kind = RESULT_DELIVER;
      r.result_seq = held_seq[head_idx];
      r.delivered_handle = held_handle[head_idx];
      r.delivered_length = held_length[head_idx];
      arrival_results.push_back(r);
      occupied[head_idx] = 1'b0;
      head_idx = (head_idx + 1) % w;
      base_seq = (base_seq < top) ? base_seq + 1 : 32'(start_reg);
    end
    r = arrival_results[arrival_results.size() - 1];
    r.last_result = 1'b1;
    arrival_results[arrival_results.size() - 1] = r;
  endfunction

  function automatic out_item_t ack_res(logic [SEQ_W-1:0] seq, logic last);
    out_item_t r;
    r = '0;
    r.result_kind = RESULT_ACK;
    r.result_seq = seq;
    r.last_result = last;
    return r;
  endfunction

  function automatic out_item_t dlv_res(logic [SEQ_W-1:0] seq, logic [HANDLE_W-1:0] h,
                                        logic [LEN_W-1:0] len, logic last);
    out_item_t r;
    r = ack_res(seq, last);
    r.result_kind = RESULT_DELIVER;
    r.delivered_handle = h;
    r.delivered_length = len;
    return r;
  endfunction

  function automatic script_row_t pkt_row(logic [SEQ_W-1:0] seq, logic [HANDLE_W-1:0] h,
                                          logic [LEN_W-1:0] len, int n,
                                          out_item_t a, out_item_t b);
    script_row_t row;
    row = '0;
    row.pkt.packet_seq = seq;
    row.pkt.packet_handle = h;
    row.pkt.packet_length = len;
    row.n_typed = n;
    row.first_res = a;
    row.second_res = b;
    return row;
  endfunction

  function automatic script_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] val);
    script_row_t row;
    row = '0;
    row.is_reg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic int gap_cycles();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) return 0;
    if (pick < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // mostly in-window traffic, with some out of window and out of space noise
  function automatic in_item_t random_packet();
    in_item_t p;
    int unsigned w, top, span, s, pick;
    w = window_slots();
    top = 32'(start_reg) + 2 * w;
    span = 2 * w + 1;
    pick = $urandom_range(99);
    if (pick < 72) begin
      s = base_seq + $urandom_range(w - 1, 0);
      if (s > top) s -= span;
    end else if (pick < 82) begin
      s = base_seq + $urandom_range(2 * w, w);
      if (s > top) s -= span;
    end else if (pick < 90) begin
      if ($urandom_range(1, 0) == 1) s = top + 1 + $urandom_range(3, 0);
      else s = 32'(start_reg) - 1 - $urandom_range(3, 0);
    end else begin
      s = $urandom;
    end
    p.packet_seq = s[SEQ_W-1:0];
    p.packet_handle = HANDLE_W'($urandom);
    if ($urandom_range(99) < 85) p.packet_length = LEN_W'($urandom_range(MAX_PAYLOAD, 0));
    else p.packet_length = LEN_W'($urandom_range(2047, MAX_PAYLOAD + 1));
    return p;
  endfunction

  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic offer(in_item_t p, int n, out_item_t a, out_item_t b);
    @(negedge clk);
    push <= 1'b1;
    in_data <= p;
    typed_n = n;
    typed_a = a;
    typed_b = b;
    do @(posedge clk); while (full);
  endtask

  task automatic idle_input(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      push <= 1'b0;
    end
  endtask

  // drop the input, drain every pending result, let the engine go quiet
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (awaiting_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n) begin
      if (cfg_we) begin
        load_register(cfg_index, cfg_data);
        reg_writes++;
      end
      if (push && !full) begin
        window_receive(in_data);
        packets_taken++;
        if (typed_n > 0) begin
          awaiting_results.push_back(typed_a);
          if (typed_n > 1) awaiting_results.push_back(typed_b);
        end else begin
          foreach (arrival_results[i]) awaiting_results.push_back(arrival_results[i]);
        end
      end
      if (pop && !empty) begin
        results_seen++;
        if (out_data.result_kind == RESULT_DELIVER) deliveries_seen++;
        if (awaiting_results.size() == 0) begin
          flag_mismatch("result with no request pending", 64'(out_data.result_seq), 64'(0));
        end else begin
          want = awaiting_results.pop_front();
          if (out_data.result_kind != want.result_kind)
            flag_mismatch("result_kind", 64'(out_data.result_kind), 64'(want.result_kind));
          if (out_data.result_seq != want.result_seq)
            flag_mismatch("result_seq", 64'(out_data.result_seq), 64'(want.result_seq));
          if (out_data.delivered_handle != want.delivered_handle)
            flag_mismatch("delivered_handle", 64'(out_data.delivered_handle),
                          64'(want.delivered_handle));
          if (out_data.delivered_length != want.delivered_length)
            flag_mismatch("delivered_length", 64'(out_data.delivered_length),
                          64'(want.delivered_length));
          if (out_data.last_result != want.last_result)
            flag_mismatch("last_result", 64'(out_data.last_result), 64'(want.last_result));
        end
      end
    end
  end

  initial begin : receiver
    int idle_left, burst_left, hold_left, pick;
    idle_left = 0;
    burst_left = 0;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        pop <= 1'b1;
      end else if (idle_left > 0) begin
        idle_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        pick = $urandom_range(99);
        if (pick < 4) burst_left = 60;
        else idle_left = gap_cycles();
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("Timeout after %0d cycles without a request", quiet);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [WSIZE_W-1:0]    ph_size [PHASES];
    logic [CFG_DATA_W-1:0] val;
    logic [START_W-1:0]    start_pick;
    bit                    no_gaps;
    int                    directed_count;
    out_item_t             none;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    push = 1'b0;
    in_data = '0;
    typed_n = 0;
    typed_a = '0;
    typed_b = '0;
    none = '0;
    size_reg = WSIZE_RESET;
    start_reg = START_RESET;
    restart_window();

    ph_size = '{5'd4, 5'd1, 5'd16, 5'd0, 5'd31, 5'd7, 5'd2};

    script[0]  = pkt_row(31'd0, 16'hFFFF, 11'd1024, 2, ack_res(31'd0, 1'b0),
                         dlv_res(31'd0, 16'hFFFF, 11'd1024, 1'b1));
    script[1]  = pkt_row(31'd2, 16'd1, 11'd0, 1, ack_res(31'd2, 1'b1), none);
    script[2]  = pkt_row(31'd2, 16'd2, 11'd5, 1, ack_res(31'd2, 1'b1), none);
    script[3]  = pkt_row(31'd1, 16'd3, 11'd2047, 0, none, none);
    script[4]  = pkt_row(31'h7FFFFFFF, 16'hAAAA, 11'd7, 1,
                         ack_res(31'h7FFFFFFF, 1'b1), none);
    script[5]  = pkt_row(31'd8, 16'd4, 11'd9, 1, ack_res(31'd8, 1'b1), none);
    script[6]  = pkt_row(31'd6, 16'd5, 11'd100, 0, none, none);
    script[7]  = pkt_row(31'd4, 16'd6, 11'd200, 0, none, none);
    script[8]  = pkt_row(31'd5, 16'd7, 11'd1025, 0, none, none);
    script[9]  = pkt_row(31'd3, 16'h5555, 11'd0, 0, none, none);
    script[10] = pkt_row(31'd8, 16'd9, 11'd1, 0, none, none);
    script[11] = pkt_row(31'd0, 16'd10, 11'd2, 0, none, none);
    script[12] = pkt_row(31'd7, 16'd11, 11'd3, 0, none, none);
    script[13] = reg_row(CFG_WINDOW_SIZE, '0);
    script[14] = pkt_row(31'd0, 16'd12, 11'd4, 2, ack_res(31'd0, 1'b0),
                         dlv_res(31'd0, 16'd12, 11'd4, 1'b1));
    script[15] = pkt_row(31'd2, 16'd13, 11'd5, 1, ack_res(31'd2, 1'b1), none);
    script[16] = pkt_row(31'd1, 16'd14, 11'd6, 0, none, none);
    script[17] = pkt_row(31'd2, 16'd15, 11'd1024, 0, none, none);
    script[18] = pkt_row(31'd3, 16'd16, 11'd8, 1, ack_res(31'd3, 1'b1), none);
    script[19] = reg_row(CFG_WINDOW_SIZE, 30'h3FFFFFFF);
    script[20] = reg_row(CFG_START_SEQ, 30'h3FFFFFFF);
    script[21] = pkt_row(31'h3FFFFFFE, 16'd17, 11'd9, 1,
                         ack_res(31'h3FFFFFFE, 1'b1), none);
    script[22] = pkt_row(31'h4000001F, 16'd18, 11'd10, 1,
                         ack_res(31'h4000001F, 1'b1), none);
    script[23] = pkt_row(31'h3FFFFFFF, 16'd0, 11'd0, 2, ack_res(31'h3FFFFFFF, 1'b0),
                         dlv_res(31'h3FFFFFFF, 16'd0, 11'd0, 1'b1));
    script[24] = reg_row(CFG_WINDOW_SIZE, 30'd16);
    script[25] = reg_row(CFG_START_SEQ, '0);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_reg) begin
        settle();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        offer(script[i].pkt, script[i].n_typed, script[i].first_res, script[i].second_res);
        idle_input(gap_cycles());
      end
    end
    directed_count = packets_taken;

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      val = CFG_DATA_W'($urandom);
      val[WSIZE_W-1:0] = ph_size[ph];
      write_reg(CFG_WINDOW_SIZE, val);
      if (ph == 0 || ph == 4) start_pick = '0;
      else if (ph == 1) start_pick = '1;
      else start_pick = START_W'($urandom);
      write_reg(CFG_START_SEQ, start_pick);
      no_gaps = ($urandom_range(99) < 30);
      if (ph == 2) hold_request = 1'b1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        offer(random_packet(), 0, none, none);
        if (!no_gaps && !(ph == 2 && k < HOLD_BURST)) idle_input(gap_cycles());
      end
    end

    settle();
    $display("Covered %0d packets (%0d scripted) and %0d results, %0d of them deliveries.",
             packets_taken, directed_count, results_seen, deliveries_seen);
    $display("Went through %0d register writes and %0d long receiver hold-offs.",
             reg_writes, holds_done);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/srrw_pkg.sv
rtl/srrw_fifo.sv
rtl/srrw_ram.sv
rtl/srrw_front.sv
rtl/srrw_back.sv
rtl/selective_repeat_receive_window_core.sv
bench/tb_top.sv
